>>> rtl/core/sorted_key_set_defines.svh
// Assertion macros used by the sorted key set top level.
`ifndef SORTED_KEY_SET_DEFINES_SVH
`define SORTED_KEY_SET_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SKS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sorted_key_set: check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SKS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sorted_key_set: check failed");

`endif

>>> rtl/core/sks_pkg.sv
// Shared constants and types for the sorted key set.
package sks_pkg;

    localparam int CAPACITY     = 1024;
    localparam int KEY_BITS     = 16;
    localparam int IN_KEY_BITS  = 16;
    localparam int OUT_CNT_BITS = 11;
    localparam int CNT_BITS     = $clog2(CAPACITY + 1);
    localparam int GROUP_SIZE   = 32;
    localparam int NUM_GROUPS   = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_MEMBER = 2'd0;
    localparam opcode_t OP_INSERT = 2'd1;
    localparam opcode_t OP_DELETE = 2'd2;

    // Broadcast to every cell: compare against the key bus, or shift one place.
    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } cell_cmd_t;

endpackage

>>> rtl/core/sks_cell.sv
// One storage cell of the sorted key chain: a key, its compare flags and shift logic.
module sks_cell
    import sks_pkg::*;
(
    input  logic                aclk,
    input  cell_cmd_t           cmd,
    input  logic [KEY_BITS-1:0] key_bus,
    input  logic                live,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic                left_lt,
    input  logic [KEY_BITS-1:0] right_key,
    output logic [KEY_BITS-1:0] key_q,
    output logic                lt_q,
    output logic                eq_q
);

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic                lt_reg, lt_next;
    logic                eq_reg, eq_next;

    always_comb begin
        key_next = key_reg;
        // Cells below the search point keep their key; the rest move one place.
        if (cmd.ins && !lt_reg) begin
            key_next = left_lt ? key_bus : left_key;
        end else if (cmd.del && !lt_reg) begin
            key_next = right_key;
        end
    end

    always_comb begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (cmd.cmp) begin
            lt_next = live && (key_reg < key_bus);
            eq_next = live && (key_reg == key_bus);
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
    end

    assign key_q = key_reg;
    assign lt_q  = lt_reg;
    assign eq_q  = eq_reg;

endmodule

>>> rtl/core/sks_found_tree.sv
// Two-level registered OR tree that turns the cells' match flags into one hit flag.
module sks_found_tree
    import sks_pkg::*;
(
    input  logic                aclk,
    input  logic [CAPACITY-1:0] eq_vec,
    output logic                found
);

    logic [NUM_GROUPS-1:0] grp_reg, grp_next;
    logic                  found_reg, found_next;

    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
        localparam int LO = g * GROUP_SIZE;
        localparam int HI = ((LO + GROUP_SIZE) < CAPACITY) ? (LO + GROUP_SIZE - 1)
                                                           : (CAPACITY - 1);
        assign grp_next[g] = |eq_vec[HI:LO];
    end

    assign found_next = |grp_reg;

    always_ff @(posedge aclk) begin
        grp_reg   <= grp_next;
        found_reg <= found_next;
    end

    assign found = found_reg;

endmodule

>>> rtl/core/sorted_key_set.sv
// Sorted key set top level: cell chain, hit tree, sequencer and result register.
// Each item is handled in order: broadcast compare in the cells, two OR-tree stages,
// then one shift of the cell chain with the result registered; s_ready stays low until
// the item is done, so items do not overlap, and a stalled result holds the shift back.
// Reset: synchronous, active low; the set is empty, cell keys are not cleared.
module sorted_key_set
    import sks_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_opcode,
    input  logic [IN_KEY_BITS-1:0]  s_key,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_success,
    output logic                    m_full_refused,
    output logic [OUT_CNT_BITS-1:0] m_entry_count
);

`include "sorted_key_set_defines.svh"

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_GROUP = 4'b0010,
        ST_FIND  = 4'b0100,
        ST_APPLY = 4'b1000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    opcode_t             op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    logic                    m_valid_reg, m_valid_next;
    logic                    m_success_reg, m_success_next;
    logic                    m_full_reg, m_full_next;
    logic [OUT_CNT_BITS-1:0] m_count_reg, m_count_next;

    logic                in_xfer;
    logic                out_free;
    logic                go;
    logic                found;
    logic                full;
    logic                do_ins, do_del, ok, refused;
    logic [KEY_BITS-1:0] key_bus;
    cell_cmd_t           cmd;

    logic [KEY_BITS-1:0] key_q [CAPACITY];
    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] eq_vec;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign go       = (state_reg == ST_APPLY) && out_free;
    assign full     = (count_reg == CNT_BITS'(CAPACITY));

    // The compare uses the incoming key directly; later steps use the held copy.
    assign key_bus = in_xfer ? KEY_BITS'(s_key) : key_reg;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_BITS-1:0] left_key;
        logic                left_lt;
        logic [KEY_BITS-1:0] right_key;

        if (i == 0) begin : g_head
            assign left_key = key_bus;
            assign left_lt  = 1'b1;
        end else begin : g_body
            assign left_key = key_q[i-1];
            assign left_lt  = lt_vec[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_key = key_q[i];
        end else begin : g_mid
            assign right_key = key_q[i+1];
        end

        sks_cell u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .key_bus   (key_bus),
            .live      (CNT_BITS'(i) < count_reg),
            .left_key  (left_key),
            .left_lt   (left_lt),
            .right_key (right_key),
            .key_q     (key_q[i]),
            .lt_q      (lt_vec[i]),
            .eq_q      (eq_vec[i])
        );
    end

    sks_found_tree u_found_tree (
        .aclk   (aclk),
        .eq_vec (eq_vec),
        .found  (found)
    );

    always_comb begin
        do_ins  = 1'b0;
        do_del  = 1'b0;
        ok      = 1'b0;
        refused = 1'b0;
        case (op_reg)
            OP_MEMBER: begin
                ok = found;
            end
            OP_INSERT: begin
                if (!found && full) begin
                    refused = 1'b1;
                end else if (!found) begin
                    do_ins = 1'b1;
                    ok     = 1'b1;
                end
            end
            OP_DELETE: begin
                do_del = found;
                ok     = found;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        cmd.cmp = in_xfer;
        cmd.ins = go && do_ins;
        cmd.del = go && do_del;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_xfer) state_next = ST_GROUP;
            ST_GROUP: state_next = ST_FIND;
            ST_FIND:  state_next = ST_APPLY;
            ST_APPLY: if (go) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op_next  = op_reg;
        key_next = key_reg;
        if (in_xfer) begin
            op_next  = s_opcode;
            key_next = KEY_BITS'(s_key);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.del) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_success_next = m_success_reg;
        m_full_next    = m_full_reg;
        m_count_next   = m_count_reg;
        if (go) begin
            m_valid_next   = 1'b1;
            m_success_next = ok;
            m_full_next    = refused;
            m_count_next   = OUT_CNT_BITS'(count_next);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        m_success_reg <= m_success_next;
        m_full_reg    <= m_full_next;
        m_count_reg   <= m_count_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_success      = m_success_reg;
    assign m_full_refused = m_full_reg;
    assign m_entry_count  = m_count_reg;

    `SKS_ASSERT_NOW(a_count_in_range, aclk, aresetn, 1'b1, count_reg <= CNT_BITS'(CAPACITY))
    `SKS_ASSERT_NOW(a_one_shift_kind, aclk, aresetn, 1'b1, !(cmd.ins && cmd.del))
    `SKS_ASSERT_NEXT(a_insert_counts, aclk, aresetn, cmd.ins, count_reg == $past(count_reg) + 1'b1)
    `SKS_ASSERT_NOW(a_refused_fails, aclk, aresetn, m_valid_reg, !(m_full_reg && m_success_reg))
    `SKS_ASSERT_NOW(a_shift_needs_room, aclk, aresetn, go, out_free)

endmodule
